// File: rtl/bmp_rle_palette_decoder_defines.svh
// assertion macros for the bmp rle palette decoder
// used by bmp_rle_palette_decoder.sv; expects clk_i and rst_ni in scope
`ifndef BMP_RLE_PALETTE_DECODER_DEFINES_SVH
`define BMP_RLE_PALETTE_DECODER_DEFINES_SVH

// property must hold at every clock outside reset
`define BRPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock outside reset
`define BRPD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/brpd_pkg.sv
// types and codes for the bmp rle palette decoder
// no dependencies; used by bmp_rle_palette_decoder.sv
`timescale 1ns / 1ps

package brpd_pkg;

  localparam int CfgW   = 13;
  localparam int CfgIdxW = 3;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS,
    PH_PAD
  } phase_e;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_RLE8  = 2'd1,
    MODE_RLE4  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE   = 3'd0,
    REG_VCOLS  = 3'd1,
    REG_VROWS  = 3'd2,
    REG_SKIP   = 3'd3,
    REG_STRIDE = 3'd4
  } reg_idx_e;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // control of one result held between the parse stage and the output register
  typedef struct packed {
    logic       marker;
    logic       four;
    logic       oob;
    logic [7:0] cnt;
    logic       row_done;
    logic       image_done;
  } res_t;

endpackage

// File: rtl/bmp_rle_palette_decoder.sv
// bmp pixel-data decoder: uncompressed 8-bit, rle8 and rle4 with palette lookup
// depends on brpd_pkg and bmp_rle_palette_decoder_defines.svh
//
// input channel (in_valid_i / in_stall_o): one word per byte of pixel data, or
// one palette entry write. a data word with first_of_image_i set restarts row
// and skip counting. palette entries must be written before they are used.
// output channel (out_valid_o / out_stall_i): one word per drawn run or marker,
// first/second colors alternate over pixel_count pixels; row_done and
// image_done flag row and image ends. many input words produce no output word.
// an accepted input word is parsed and its palette entries are read into the
// parse stage registers; the result then moves on to the output register.
// throughput: one input word per cycle, set by the single parse stage and the
// two-read-port palette memory; in_stall_o rises only when both the parse
// stage and the output register hold results and the receiver stalls.
// reset: parser and counters are cleared, configuration returns to rle8,
// 320 x 240 visible, no skipped rows, 320-byte stride; palette contents are
// left as they are. a stalled output word holds its value.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
`timescale 1ns / 1ps
`include "bmp_rle_palette_decoder_defines.svh"

module bmp_rle_palette_decoder #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_COLUMNS   = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [brpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [brpd_pkg::CfgW-1:0]    cfg_wdata_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_of_image_i,
  input  logic [7:0]                   palette_index_i,
  input  logic [23:0]                  palette_color_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [23:0]                  first_color_o,
  output logic [23:0]                  second_color_o,
  output logic [7:0]                   pixel_count_o,
  output logic                         row_done_o,
  output logic                         image_done_o
);

  localparam int PalAw = $clog2(PALETTE_DEPTH);
  localparam int ColW  = $clog2(MAX_COLUMNS + 2);
  localparam int CmpW  = ColW + 8;

  // configuration
  logic [1:0]  mode_q;
  logic [10:0] vcols_q;
  logic [10:0] vrows_q;
  logic [11:0] skip_cfg_q;
  logic [12:0] stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= brpd_pkg::MODE_RLE8;
      vcols_q    <= 11'd320;
      vrows_q    <= 11'd240;
      skip_cfg_q <= 12'd0;
      stride_q   <= 13'd320;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brpd_pkg::REG_MODE:   mode_q     <= cfg_wdata_i[1:0];
        brpd_pkg::REG_VCOLS:  vcols_q    <= cfg_wdata_i[10:0];
        brpd_pkg::REG_VROWS:  vrows_q    <= cfg_wdata_i[10:0];
        brpd_pkg::REG_SKIP:   skip_cfg_q <= cfg_wdata_i[11:0];
        brpd_pkg::REG_STRIDE: stride_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // parser state
  brpd_pkg::phase_e phase_q, phase_d, e_phase;
  logic [7:0]       run_q, run_d, e_run;
  logic [7:0]       abs_q, abs_d, e_abs;
  logic             pad_q, pad_d, e_pad;
  logic [ColW-1:0]  col_q, col_d, e_col;
  logic [11:0]      row_q, row_d, e_row;
  logic [11:0]      skip_q, skip_d, e_skip;
  logic [12:0]      bir_q, bir_d, e_bir;
  logic             crop_q, crop_d, e_crop;
  logic             fin_q, fin_d, e_fin;

  // pipeline
  logic                s1_valid_q;
  brpd_pkg::res_t      s1_q, res;
  logic                res_v;
  logic                out_valid_q;
  logic [23:0]         first_q, second_q;
  logic [7:0]          cnt_q;
  logic                rd_q, id_q;
  logic                s1_adv, accept, is_data, restart, data_go;

  assign is_data = (operation_i == brpd_pkg::OP_DATA);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign restart = is_data && first_of_image_i;

  // state as seen by this word, after an image restart
  assign e_phase = restart ? brpd_pkg::PH_COUNT : phase_q;
  assign e_run   = restart ? 8'd0 : run_q;
  assign e_abs   = restart ? 8'd0 : abs_q;
  assign e_pad   = restart ? 1'b0 : pad_q;
  assign e_col   = restart ? '0 : col_q;
  assign e_row   = restart ? 12'd0 : row_q;
  assign e_skip  = restart ? skip_cfg_q : skip_q;
  assign e_bir   = restart ? 13'd0 : bir_q;
  assign e_crop  = restart ? 1'b0 : crop_q;
  assign e_fin   = restart ? 1'b0 : fin_q;

  assign data_go = accept && is_data && !e_fin;

  // derived limits
  logic [12:0]     vc13;
  logic [ColW-1:0] vc;
  logic [10:0]     vr;
  logic [12:0]     stride;
  logic            four;

  assign vc13   = (vcols_q == 11'd0) ? 13'd1 : {2'b00, vcols_q};
  assign vc     = (vc13 > 13'(MAX_COLUMNS)) ? ColW'(MAX_COLUMNS) : ColW'(vc13);
  assign vr     = (vrows_q == 11'd0) ? 11'd1 : vrows_q;
  assign stride = (stride_q == 13'd0) ? 13'd1 : stride_q;
  assign four   = (mode_q == brpd_pkg::MODE_RLE4);

  // first palette index of the word and its range check
  logic [7:0]       idx_a;
  logic             oob_a;

  assign idx_a  = four ? {4'd0, data_byte_i[7:4]} : data_byte_i;
  assign oob_a  = {1'b0, idx_a} >= 9'(PALETTE_DEPTH);

  // row end and plain-mode stride tracking
  logic [11:0]     row_p1;
  logic            row_fin;
  logic [13:0]     bir_p1;
  logic            last;
  logic [ColW-1:0] col_p1;

  assign row_p1  = e_row + 12'd1;
  assign row_fin = row_p1 >= {1'b0, vr};
  assign bir_p1  = {1'b0, e_bir} + 14'd1;
  assign last    = bir_p1 >= {1'b0, stride};
  assign col_p1  = e_col + ColW'(1);

  // cropped run drawing
  logic [7:0]      abs_n, show_n, show_cnt;
  logic [ColW-1:0] avail, col_after;
  logic            show_ok, show_rd, use_show;

  assign abs_n     = (four && e_abs >= 8'd2) ? 8'd2 : 8'd1;
  assign show_n    = (e_phase == brpd_pkg::PH_ABS) ? abs_n : e_run;
  assign avail     = (e_col < vc) ? vc - e_col : '0;
  assign show_cnt  = (CmpW'(show_n) < CmpW'(avail)) ? show_n : 8'(avail);
  assign col_after = e_col + ColW'(show_cnt);
  assign show_rd   = col_after >= vc;
  assign show_ok   = (e_skip == 12'd0) && !e_crop && (show_n != 8'd0);

  always_comb begin
    phase_d  = accept && is_data ? e_phase : phase_q;
    run_d    = accept && is_data ? e_run   : run_q;
    abs_d    = accept && is_data ? e_abs   : abs_q;
    pad_d    = accept && is_data ? e_pad   : pad_q;
    col_d    = accept && is_data ? e_col   : col_q;
    row_d    = accept && is_data ? e_row   : row_q;
    skip_d   = accept && is_data ? e_skip  : skip_q;
    bir_d    = accept && is_data ? e_bir   : bir_q;
    crop_d   = accept && is_data ? e_crop  : crop_q;
    fin_d    = accept && is_data ? e_fin   : fin_q;
    res_v    = 1'b0;
    res      = '0;
    res.four = four;
    res.oob  = oob_a;
    use_show = 1'b0;
    if (data_go) begin
      unique case (mode_q) inside
        brpd_pkg::MODE_PLAIN: begin
          bir_d = last ? 13'd0 : bir_p1[12:0];
          if (e_skip != 12'd0) begin
            if (last) skip_d = e_skip - 12'd1;
          end else if (e_crop) begin
            if (last) begin
              crop_d = 1'b0;
              col_d  = '0;
            end
          end else begin
            res_v   = 1'b1;
            res.cnt = 8'd1;
            col_d   = col_p1;
            if (col_p1 >= vc || last) begin
              res.row_done   = 1'b1;
              res.image_done = row_fin;
              row_d          = row_p1;
              fin_d          = row_fin;
              if (last) col_d = '0;
              else crop_d = 1'b1;
            end
          end
        end
        brpd_pkg::MODE_RLE8, brpd_pkg::MODE_RLE4: begin
          unique case (e_phase)
            brpd_pkg::PH_COUNT: begin
              if (data_byte_i != 8'd0) begin
                run_d   = data_byte_i;
                phase_d = brpd_pkg::PH_VALUE;
              end else begin
                phase_d = brpd_pkg::PH_ESCAPE;
              end
            end
            brpd_pkg::PH_VALUE: begin
              phase_d  = brpd_pkg::PH_COUNT;
              use_show = 1'b1;
            end
            brpd_pkg::PH_ESCAPE: begin
              phase_d = brpd_pkg::PH_COUNT;
              if (data_byte_i == brpd_pkg::ESC_EOL) begin
                col_d = '0;
                if (e_skip != 12'd0) begin
                  skip_d = e_skip - 12'd1;
                end else if (e_crop) begin
                  crop_d = 1'b0;
                end else begin
                  res_v          = 1'b1;
                  res.marker     = 1'b1;
                  res.row_done   = 1'b1;
                  res.image_done = row_fin;
                  row_d          = row_p1;
                  fin_d          = row_fin;
                end
              end else if (data_byte_i == brpd_pkg::ESC_EOB) begin
                fin_d          = 1'b1;
                res_v          = 1'b1;
                res.marker     = 1'b1;
                res.row_done   = (e_skip == 12'd0) && !e_crop && (e_col != '0);
                res.image_done = 1'b1;
              end else if (data_byte_i == brpd_pkg::ESC_DELTA) begin
                phase_d = brpd_pkg::PH_DELTA_X;
              end else begin
                abs_d   = data_byte_i;
                pad_d   = four ? (data_byte_i[1:0] == 2'b01 || data_byte_i[1:0] == 2'b10)
                               : data_byte_i[0];
                phase_d = brpd_pkg::PH_ABS;
              end
            end
            brpd_pkg::PH_DELTA_X: phase_d = brpd_pkg::PH_DELTA_Y;
            brpd_pkg::PH_DELTA_Y: phase_d = brpd_pkg::PH_COUNT;
            brpd_pkg::PH_ABS: begin
              use_show = 1'b1;
              if (e_abs > abs_n) begin
                abs_d = e_abs - abs_n;
              end else begin
                abs_d   = 8'd0;
                phase_d = e_pad ? brpd_pkg::PH_PAD : brpd_pkg::PH_COUNT;
              end
            end
            default: phase_d = brpd_pkg::PH_COUNT;
          endcase
        end
        default: ;
      endcase
      if (use_show && show_ok) begin
        res_v   = 1'b1;
        res.cnt = show_cnt;
        col_d   = col_after;
        if (show_rd) begin
          res.row_done   = 1'b1;
          res.image_done = row_fin;
          crop_d         = 1'b1;
          row_d          = row_p1;
          fin_d          = row_fin;
        end
      end
    end
  end

  // palette memory, two read ports for the rle4 nibble pair
  logic [23:0]      pal_mem [PALETTE_DEPTH];
  logic [23:0]      rdata_a_q, rdata_b_q;
  logic             pal_we;
  logic [PalAw-1:0] addr_a, addr_b, addr_w;

  assign addr_a = idx_a[PalAw-1:0];
  assign addr_b = PalAw'(data_byte_i[3:0]);
  assign addr_w = palette_index_i[PalAw-1:0];
  assign pal_we = accept && !is_data && ({1'b0, palette_index_i} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[addr_w] <= palette_color_i;
    if (data_go) begin
      if (!oob_a) rdata_a_q <= pal_mem[addr_a];
      rdata_b_q <= pal_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= brpd_pkg::PH_COUNT;
      run_q   <= 8'd0;
      abs_q   <= 8'd0;
      pad_q   <= 1'b0;
      col_q   <= '0;
      row_q   <= 12'd0;
      skip_q  <= 12'd0;
      bir_q   <= 13'd0;
      crop_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      abs_q   <= abs_d;
      pad_q   <= pad_d;
      col_q   <= col_d;
      row_q   <= row_d;
      skip_q  <= skip_d;
      bir_q   <= bir_d;
      crop_q  <= crop_d;
      fin_q   <= fin_d;
    end
  end

  // parse stage result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= res_v;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
  end

  // output register
  logic [23:0] first_d;
  assign first_d = (s1_q.marker || s1_q.oob) ? 24'd0 : rdata_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      first_q  <= first_d;
      second_q <= s1_q.marker ? 24'd0 : (s1_q.four ? rdata_b_q : first_d);
      cnt_q    <= s1_q.cnt;
      rd_q     <= s1_q.row_done;
      id_q     <= s1_q.image_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_color_o  = first_q;
  assign second_color_o = second_q;
  assign pixel_count_o  = cnt_q;
  assign row_done_o     = rd_q;
  assign image_done_o   = id_q;

  `BRPD_ASSERT(a_fin_holds, fin_q && !(accept && restart) |=> fin_q, "finished flag dropped")
  `BRPD_ASSERT(a_s1_holds, s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_q), "parse stage lost")
  `BRPD_ASSERT(a_out_refill, out_valid_q && !out_stall_i && s1_valid_q |=> out_valid_q, "output not refilled")
  `BRPD_NEVER(a_no_px_skip, accept && res_v && !res.marker && (e_skip != 12'd0), "pixels in skipped row")

endmodule

// File: tb/tb_bmp_rle_palette_decoder.sv
// self-checking testbench for bmp_rle_palette_decoder: plain, rle8 and rle4 pixel data
// with palette loads, several register settings, random idling and a long output hold
// depends on brpd_pkg and the decoder rtl; carries its own decoder predictor
`timescale 1ns / 1ps

module tb_bmp_rle_palette_decoder;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         COLS_MAX    = 1024;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] ESC_LEAD    = 8'd0;

  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        first;
    logic [7:0]  pidx;
    logic [23:0] pcolor;
  } pix_word_t;

  typedef struct packed {
    logic [23:0] c1;
    logic [23:0] c2;
    logic [7:0]  cnt;
    logic        rd;
    logic        id;
  } run_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [brpd_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [brpd_pkg::CfgW-1:0]     cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          operation_i = 1'b0;
  logic [7:0]                    data_byte_i = '0;
  logic                          first_of_image_i = 1'b0;
  logic [7:0]                    palette_index_i = '0;
  logic [23:0]                   palette_color_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [23:0]                   first_color_o;
  logic [23:0]                   second_color_o;
  logic [7:0]                    pixel_count_o;
  logic                          row_done_o;
  logic                          image_done_o;

  bmp_rle_palette_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .first_of_image_i (first_of_image_i),
    .palette_index_i  (palette_index_i),
    .palette_color_i  (palette_color_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_color_o    (first_color_o),
    .second_color_o   (second_color_o),
    .pixel_count_o    (pixel_count_o),
    .row_done_o       (row_done_o),
    .image_done_o     (image_done_o)
  );

  // decoder shadow: registers, parse state and palette
  logic [1:0]        mode = brpd_pkg::MODE_RLE8;
  logic [10:0]       vcols = 11'd320;
  logic [10:0]       vrows = 11'd240;
  logic [11:0]       skip_cfg = '0;
  logic [12:0]       stride = 13'd320;
  brpd_pkg::phase_e  parse_ph = brpd_pkg::PH_COUNT;
  logic [7:0]        run_len = '0;
  logic [7:0]        abs_left = '0;
  logic              pad_pend = 1'b0;
  logic [11:0]       col_cnt = '0;
  logic [11:0]       row_cnt = '0;
  logic [11:0]       skip_left = '0;
  logic [12:0]       byte_in_row = '0;
  logic              cropping = 1'b0;
  logic              finished = 1'b0;
  logic [23:0]       shade_mem [256];

  pix_word_t   words_to_send[$];
  run_word_t   runs_due[$];
  pix_word_t   cur_word;
  run_word_t   want;
  bit          word_taken = 1'b0;
  bit          open_image = 1'b0;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          phase_words = 0;
  int          n_in = 0;
  int          n_checked = 0;
  int          n_fail = 0;
  int          n_settings = 0;
  int          cycle_cnt = 0;

  function automatic void queue_run(input logic [23:0] c1, c2, input logic [7:0] cnt,
                                    input bit rd, id);
    run_word_t r;
    r.c1 = c1;
    r.c2 = c2;
    r.cnt = cnt;
    r.rd = rd;
    r.id = id;
    runs_due.push_back(r);
  endfunction

  function automatic int cols_eff();
    int v;
    v = (vcols == 0) ? 1 : int'(vcols);
    return (v > COLS_MAX) ? COLS_MAX : v;
  endfunction

  function automatic bit close_row();
    int vr;
    vr = (vrows == 0) ? 1 : int'(vrows);
    row_cnt = row_cnt + 1'b1;
    if (int'(row_cnt) >= vr) finished = 1'b1;
    return finished;
  endfunction

  function automatic void show_run(input logic [23:0] c1, c2, input int n);
    int vc;
    int avail;
    int cnt;
    bit rd;
    bit id;
    if (skip_left != 0 || cropping || n == 0) return;
    vc = cols_eff();
    avail = (int'(col_cnt) < vc) ? vc - int'(col_cnt) : 0;
    cnt = (n < avail) ? n : avail;
    col_cnt = col_cnt + cnt[11:0];
    rd = int'(col_cnt) >= vc;
    id = 1'b0;
    if (rd) begin
      cropping = 1'b1;
      id = close_row();
    end
    queue_run(c1, c2, cnt[7:0], rd, id);
  endfunction

  function automatic void decode_plain(input logic [7:0] b);
    int stride_e;
    bit last;
    bit id;
    logic [23:0] c;
    stride_e = (stride == 0) ? 1 : int'(stride);
    last = (int'(byte_in_row) + 1) >= stride_e;
    if (last) byte_in_row = '0;
    else byte_in_row = byte_in_row + 1'b1;
    if (skip_left != 0) begin
      if (last) skip_left = skip_left - 1'b1;
      return;
    end
    if (cropping) begin
      if (last) begin
        cropping = 1'b0;
        col_cnt = '0;
      end
      return;
    end
    c = shade_mem[b];
    col_cnt = col_cnt + 1'b1;
    if (int'(col_cnt) >= cols_eff() || last) begin
      id = close_row();
      if (last) col_cnt = '0;
      else cropping = 1'b1;
      queue_run(c, c, 8'd1, 1'b1, id);
    end else begin
      queue_run(c, c, 8'd1, 1'b0, 1'b0);
    end
  endfunction

  function automatic void decode_rle(input logic [7:0] b, input bit four);
    int n;
    bit rd;
    bit id;
    case (parse_ph)
      brpd_pkg::PH_COUNT: begin
        if (b != 0) begin
          run_len = b;
          parse_ph = brpd_pkg::PH_VALUE;
        end else begin
          parse_ph = brpd_pkg::PH_ESCAPE;
        end
      end
      brpd_pkg::PH_VALUE: begin
        parse_ph = brpd_pkg::PH_COUNT;
        if (four) show_run(shade_mem[b[7:4]], shade_mem[b[3:0]], int'(run_len));
        else show_run(shade_mem[b], shade_mem[b], int'(run_len));
      end
      brpd_pkg::PH_ESCAPE: begin
        parse_ph = brpd_pkg::PH_COUNT;
        if (b == brpd_pkg::ESC_EOL) begin
          if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
            col_cnt = '0;
          end else if (cropping) begin
            cropping = 1'b0;
            col_cnt = '0;
          end else begin
            col_cnt = '0;
            id = close_row();
            queue_run('0, '0, '0, 1'b1, id);
          end
        end else if (b == brpd_pkg::ESC_EOB) begin
          rd = (skip_left == 0 && !cropping && col_cnt != 0);
          finished = 1'b1;
          queue_run('0, '0, '0, rd, 1'b1);
        end else if (b == brpd_pkg::ESC_DELTA) begin
          parse_ph = brpd_pkg::PH_DELTA_X;
        end else begin
          abs_left = b;
          pad_pend = four ? (b[1:0] == 2'b01 || b[1:0] == 2'b10) : b[0];
          parse_ph = brpd_pkg::PH_ABS;
        end
      end
      brpd_pkg::PH_DELTA_X: parse_ph = brpd_pkg::PH_DELTA_Y;
      brpd_pkg::PH_DELTA_Y: parse_ph = brpd_pkg::PH_COUNT;
      brpd_pkg::PH_ABS: begin
        n = (four && abs_left >= 2) ? 2 : 1;
        if (int'(abs_left) > n) begin
          abs_left = abs_left - n[7:0];
        end else begin
          abs_left = '0;
          if (pad_pend) parse_ph = brpd_pkg::PH_PAD;
          else parse_ph = brpd_pkg::PH_COUNT;
        end
        if (four) show_run(shade_mem[b[7:4]], shade_mem[b[3:0]], n);
        else show_run(shade_mem[b], shade_mem[b], n);
      end
      default: parse_ph = brpd_pkg::PH_COUNT;
    endcase
  endfunction

  function automatic void decode_word(input pix_word_t w);
    if (w.op == brpd_pkg::OP_PALETTE) begin
      shade_mem[w.pidx] = w.pcolor;
      return;
    end
    if (w.first) begin
      parse_ph = brpd_pkg::PH_COUNT;
      run_len = '0;
      abs_left = '0;
      pad_pend = 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      skip_left = skip_cfg;
      byte_in_row = '0;
      cropping = 1'b0;
      finished = 1'b0;
    end
    if (finished) return;
    case (mode)
      brpd_pkg::MODE_PLAIN: decode_plain(w.data);
      brpd_pkg::MODE_RLE8:  decode_rle(w.data, 1'b0);
      brpd_pkg::MODE_RLE4:  decode_rle(w.data, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void send_byte(input logic [7:0] b);
    pix_word_t w;
    w.op = brpd_pkg::OP_DATA;
    w.data = b;
    w.first = open_image;
    w.pidx = 8'($urandom);
    w.pcolor = 24'($urandom);
    open_image = 1'b0;
    words_to_send.push_back(w);
    phase_words++;
  endfunction

  function automatic void send_palette(input logic [7:0] idx, input logic [23:0] col);
    pix_word_t w;
    w.op = brpd_pkg::OP_PALETTE;
    w.data = 8'($urandom);
    w.first = 1'($urandom);
    w.pidx = idx;
    w.pcolor = col;
    words_to_send.push_back(w);
    phase_words++;
  endfunction

  function automatic void make_rle_image(input bit four);
    int rows;
    int ops;
    int len;
    int nbytes;
    int pick;
    open_image = 1'b1;
    rows = $urandom_range(1, 5);
    for (int r = 0; r < rows; r++) begin
      ops = $urandom_range(1, 6);
      for (int o = 0; o < ops; o++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_palette(8'($urandom), 24'($urandom));
        end else if (pick < 60) begin
          send_byte(8'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 6)));
          send_byte(8'($urandom));
        end else if (pick < 85) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
          nbytes = four ? (len + 1) / 2 : len;
          send_byte(ESC_LEAD);
          send_byte(len[7:0]);
          for (int i = 0; i < nbytes; i++) send_byte(8'($urandom));
          if (nbytes % 2 != 0) send_byte(8'($urandom));
        end else if (pick < 92) begin
          send_byte(ESC_LEAD);
          send_byte(brpd_pkg::ESC_DELTA);
          send_byte(8'($urandom));
          send_byte(8'($urandom));
        end else begin
          send_byte(8'($urandom));
        end
      end
      send_byte(ESC_LEAD);
      send_byte(brpd_pkg::ESC_EOL);
    end
    if ($urandom_range(0, 9) < 7) begin
      send_byte(ESC_LEAD);
      send_byte(brpd_pkg::ESC_EOB);
    end
    if ($urandom_range(0, 4) == 0) send_byte(8'($urandom));
  endfunction

  function automatic void make_plain_image();
    int rows;
    int per_row;
    int stride_e;
    int extra;
    open_image = 1'b1;
    stride_e = (stride == 0) ? 1 : int'(stride);
    per_row = (stride_e > 48) ? 48 : stride_e;
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < per_row; i++) begin
        if ($urandom_range(0, 99) < 3) send_palette(8'($urandom), 24'($urandom));
        send_byte(8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      extra = $urandom_range(1, per_row);
      for (int i = 0; i < extra; i++) send_byte(8'($urandom));
    end
  endfunction

  task automatic write_reg(input brpd_pkg::reg_idx_e idx, input logic [12:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      brpd_pkg::REG_MODE:   mode = value[1:0];
      brpd_pkg::REG_VCOLS:  vcols = value[10:0];
      brpd_pkg::REG_VROWS:  vrows = value[10:0];
      brpd_pkg::REG_SKIP:   skip_cfg = value[11:0];
      brpd_pkg::REG_STRIDE: stride = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] m, input int vc, vr, sk, st);
    write_reg(brpd_pkg::REG_MODE, 13'(m));
    write_reg(brpd_pkg::REG_VCOLS, 13'(vc));
    write_reg(brpd_pkg::REG_VROWS, 13'(vr));
    write_reg(brpd_pkg::REG_SKIP, 13'(sk));
    write_reg(brpd_pkg::REG_STRIDE, 13'(st));
    n_settings++;
  endtask

  // wait until every word is taken and every run has come out
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs outstanding", cycle_cnt, runs_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      word_taken = 1'b0;
      if (words_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        cur_word = words_to_send.pop_front();
        operation_i <= cur_word.op;
        data_byte_i <= cur_word.data;
        first_of_image_i <= cur_word.first;
        palette_index_i <= cur_word.pidx;
        palette_color_i <= cur_word.pcolor;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decode_word(cur_word);
      word_taken = 1'b1;
      n_in++;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 150;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (runs_due.size() == 0) begin
        $error("output word with nothing expected");
        n_fail++;
      end else begin
        want = runs_due.pop_front();
        if (first_color_o !== want.c1) begin
          $error("first_color expected %06h got %06h", want.c1, first_color_o);
          n_fail++;
        end
        if (second_color_o !== want.c2) begin
          $error("second_color expected %06h got %06h", want.c2, second_color_o);
          n_fail++;
        end
        if (pixel_count_o !== want.cnt) begin
          $error("pixel_count expected %0d got %0d", want.cnt, pixel_count_o);
          n_fail++;
        end
        if (row_done_o !== want.rd) begin
          $error("row_done expected %0b got %0b", want.rd, row_done_o);
          n_fail++;
        end
        if (image_done_o !== want.id) begin
          $error("image_done expected %0b got %0b", want.id, image_done_o);
          n_fail++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    logic [1:0] m;
    int vc;
    int vr;
    int sk;
    int st;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // full palette load so that no entry is read unwritten
    for (int i = 0; i < 256; i++) send_palette(8'(i), 24'($urandom));
    send_palette(8'd0, 24'h000000);
    send_palette(8'd255, 24'hffffff);
    drain();

    // rle8: cropped run, literal with pad, delta, short row, end of bitmap mid row
    configure(brpd_pkg::MODE_RLE8, 8, 3, 0, 16);
    open_image = 1'b1;
    send_byte(8'd255); send_byte(8'hff);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_EOL);
    send_byte(8'd2); send_byte(8'h00);
    send_byte(ESC_LEAD); send_byte(8'd3);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h00);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_DELTA); send_byte(8'd7); send_byte(8'd9);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_EOL);
    send_byte(8'd1); send_byte(8'h80);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_EOB);
    send_byte(8'd5);
    drain();

    // rle4: run filling the width, literal ending on a single pixel with pad
    configure(brpd_pkg::MODE_RLE4, 5, 2, 0, 16);
    open_image = 1'b1;
    send_byte(8'd5); send_byte(8'hab);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_EOL);
    send_byte(ESC_LEAD); send_byte(8'd5);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h5f); send_byte(8'h00);
    send_byte(ESC_LEAD); send_byte(brpd_pkg::ESC_EOB);
    drain();

    for (int k = 0; k < 14; k++) begin
      case (k % 3)
        0:       m = brpd_pkg::MODE_PLAIN;
        1:       m = brpd_pkg::MODE_RLE8;
        default: m = brpd_pkg::MODE_RLE4;
      endcase
      if (k == 11) m = MODE_UNUSED;
      vc = $urandom_range(1, 24);
      vr = $urandom_range(1, 6);
      sk = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
      st = $urandom_range(4, 16);
      case (k)
        0:  vc = 1;
        1:  vc = COLS_MAX;
        2:  vc = 0;
        3:  st = 4096;
        4:  vc = 2047;
        5:  vr = 1024;
        6:  st = 0;
        7:  sk = 4095;
        8:  vr = 0;
        9:  begin vc = 4; vr = 6; st = 4; end
        10: vr = 1;
        12: st = 8191;
        default: ;
      endcase
      configure(m, vc, vr, sk, st);
      calm = (k == 2 || k == 3);
      phase_words = 0;
      while (phase_words < 45) begin
        if (mode == brpd_pkg::MODE_RLE8 || mode == brpd_pkg::MODE_RLE4) begin
          make_rle_image(mode == brpd_pkg::MODE_RLE4);
        end else begin
          make_plain_image();
        end
      end
      if (k == 9) hold_go = 1'b1;
      drain();
    end
    calm = 1'b0;

    $display("checked %0d output words from %0d accepted input words", n_checked, n_in);
    $display("%0d register settings over all modes, with calm stretches and one long hold",
             n_settings);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
